[rtl/core/ida_pkg.sv]
// ----------------------------------------------------------------------------
// ida_pkg
// Shared types and constants of the id allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ida_pkg;
	localparam int LIM_W   = 11;	// id limit, fresh counter and stored ids
	localparam int DATA_W  = 16;	// width of a freed id on the request side
	localparam int GIVEN_W = 10;	// width of an id on the result side

	localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ST_ALLOC     = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_FREED     = 2'd2,
		ST_DROPPED   = 2'd3
	} status_t;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic push;
		logic pop;
	} heap_cmd_t;

	typedef struct packed {
		logic done;
		logic empty;
		logic full;
	} heap_stat_t;
endpackage
`default_nettype wire

[rtl/core/ida_mod.sv]
// ----------------------------------------------------------------------------
// ida_mod
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// ----------------------------------------------------------------------------
`default_nettype none
module ida_mod (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic [ida_pkg::DATA_W-1:0] dividend,
	input  wire logic [ida_pkg::LIM_W-1:0]  divisor,
	output logic                          done,
	output logic [ida_pkg::LIM_W-1:0]     rem
);
	import ida_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [3:0]          cnt_q;
	logic [DATA_W-1:0]   sh_q;
	logic [LIM_W-1:0]    div_q;
	logic [LIM_W-1:0]    rem_q;
	logic [LIM_W:0]      trial;
	logic [LIM_W:0]      diff;
	logic [LIM_W-1:0]    nrem;

	assign trial = {rem_q, sh_q[DATA_W-1]};
	assign diff  = trial - {1'b0, div_q};
	// partial remainder stays below the divisor, so it fits LIM_W bits
	assign nrem  = (trial >= {1'b0, div_q}) ? diff[LIM_W-1:0] : trial[LIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DATA_W-2:0], 1'b0};
			rem_q <= nrem;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

[rtl/core/ida_heap.sv]
// ----------------------------------------------------------------------------
// ida_heap
// Binary min-heap of recycled ids in a one-read one-write memory; sift up on
// push, sift down on pop, one level per read-compare-write step.
// ----------------------------------------------------------------------------
`default_nettype none
module ida_heap #(
	parameter int MAX_IDS = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ida_pkg::heap_cmd_t      cmd,
	input  wire logic [ida_pkg::LIM_W-1:0] push_val,
	output ida_pkg::heap_stat_t          stat,
	output logic [ida_pkg::LIM_W-1:0]    pop_val
);
	import ida_pkg::*;

	localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int CW = $clog2(MAX_IDS + 1);

	typedef enum logic [3:0] {
		H_IDLE, H_UP_L, H_UP_C, H_P_TOP, H_P_LAST, H_P_GET, H_P_L, H_P_C1, H_P_C2, H_P_FIN
	} hstate_t;

	hstate_t           state_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     pos_q;
	logic [LIM_W-1:0]  val_q;
	logic [LIM_W-1:0]  top_q;
	logic [LIM_W-1:0]  c1_q;
	logic              done_q;

	logic [LIM_W-1:0]  mem [MAX_IDS];
	logic [LIM_W-1:0]  rdata_s1;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [LIM_W-1:0]  wdata;

	logic [AW:0]       child;
	logic [AW:0]       child2;
	logic              has_c1;
	logic              has_c2;
	logic [AW-1:0]     parent;
	logic              c2_lt;
	logic [LIM_W-1:0]  sel_val;
	logic [AW-1:0]     sel_idx;

	assign child   = {pos_q, 1'b1};
	assign child2  = child + (AW+1)'(1);
	assign has_c1  = 32'(child) < 32'(cnt_q);
	assign has_c2  = (32'(child) + 32'd1) < 32'(cnt_q);
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign c2_lt   = rdata_s1 < c1_q;
	assign sel_val = c2_lt ? rdata_s1 : c1_q;
	assign sel_idx = c2_lt ? child2[AW-1:0] : child[AW-1:0];

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = pos_q;
		wdata = val_q;
		case (state_q)
			H_UP_L: begin
				if (pos_q == '0) we = 1'b1;
				else raddr = parent;
			end
			H_UP_C: begin
				we = 1'b1;
				if (val_q < rdata_s1) wdata = rdata_s1;
			end
			H_P_LAST: raddr = cnt_q[AW-1:0];
			H_P_L:    raddr = child[AW-1:0];
			H_P_C1: begin
				if (has_c2) raddr = child2[AW-1:0];
				else if (rdata_s1 < val_q) begin
					we    = 1'b1;
					wdata = rdata_s1;
				end
			end
			H_P_C2: begin
				if (sel_val < val_q) begin
					we    = 1'b1;
					wdata = sel_val;
				end
			end
			H_P_FIN: we = (cnt_q != '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (cmd.push) begin
						pos_q   <= cnt_q[AW-1:0];
						cnt_q   <= cnt_q + CW'(1);
						val_q   <= push_val;
						state_q <= H_UP_L;
					end else if (cmd.pop) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= H_P_TOP;
					end
				end
				H_UP_L: begin
					if (pos_q == '0) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else state_q <= H_UP_C;
				end
				H_UP_C: begin
					if (val_q < rdata_s1) begin
						pos_q   <= parent;
						state_q <= H_UP_L;
					end else begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				H_P_TOP:  state_q <= H_P_LAST;
				H_P_LAST: begin
					top_q   <= rdata_s1;
					state_q <= H_P_GET;
				end
				H_P_GET: begin
					val_q   <= rdata_s1;
					pos_q   <= '0;
					state_q <= H_P_L;
				end
				H_P_L: state_q <= has_c1 ? H_P_C1 : H_P_FIN;
				H_P_C1: begin
					if (has_c2) begin
						c1_q    <= rdata_s1;
						state_q <= H_P_C2;
					end else if (rdata_s1 < val_q) begin
						pos_q   <= child[AW-1:0];
						state_q <= H_P_L;
					end else state_q <= H_P_FIN;
				end
				H_P_C2: begin
					if (sel_val < val_q) begin
						pos_q   <= sel_idx;
						state_q <= H_P_L;
					end else state_q <= H_P_FIN;
				end
				H_P_FIN: begin
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign stat.done  = done_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(MAX_IDS));
	assign pop_val    = top_q;
endmodule
`default_nettype wire

[rtl/core/id_allocator_with_min_recycle.sv]
// ----------------------------------------------------------------------------
// id_allocator_with_min_recycle
// Hands out fresh ids from a counter, then the smallest recycled id from a
// min-heap; frees are reduced modulo the limit and pushed into the heap.
// Fresh allocate, exhausted and dropped results come straight from the idle state;
// a pop waits for the heap sift down, a free for the remainder unit and the sift up.
// One request at a time: the sift loop over the heap memory port sets the rate.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears counter, heap count and id_limit (to 1024); heap memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module id_allocator_with_min_recycle #(
	parameter int MAX_IDS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        req_type,
	input  wire logic [ida_pkg::DATA_W-1:0]  freed_id,
	input  wire logic                        id_limit_we,
	input  wire logic [ida_pkg::LIM_W-1:0]   id_limit,
	output logic                             done,
	output logic [ida_pkg::GIVEN_W-1:0]      given_id,
	output logic [1:0]                       status
);
	import ida_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_MOD, T_PUSH, T_POP} tstate_t;

	tstate_t           state_q;
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  fresh_q;
	logic              done_q;
	logic [GIVEN_W-1:0] given_q;
	status_t           status_q;
	heap_cmd_t         cmd_q;
	logic              mod_go_q;
	logic [DATA_W-1:0] fid_q;
	logic [LIM_W-1:0]  lim;
	logic              mod_done;
	logic [LIM_W-1:0]  mod_rem;
	heap_stat_t        hstat;
	logic [LIM_W-1:0]  pop_val;

	always_comb begin
		if (limit_q == '0) lim = LIM_W'(1);
		else if (32'(limit_q) > MAX_IDS) lim = LIM_W'(MAX_IDS);
		else lim = limit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (id_limit_we) limit_q <= id_limit;
	end

	ida_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go_q),
		.dividend (fid_q),
		.divisor  (lim),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	ida_heap #(.MAX_IDS(MAX_IDS)) u_heap (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_q),
		.push_val (mod_rem),
		.stat     (hstat),
		.pop_val  (pop_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			fresh_q  <= '0;
			done_q   <= 1'b0;
			given_q  <= '0;
			status_q <= ST_ALLOC;
			cmd_q    <= '0;
			mod_go_q <= 1'b0;
			fid_q    <= '0;
		end else begin
			done_q   <= 1'b0;
			cmd_q    <= '0;
			mod_go_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (start) begin
						given_q <= '0;
						if (req_type == REQ_ALLOC) begin
							if (fresh_q < lim) begin
								given_q  <= fresh_q[GIVEN_W-1:0];
								fresh_q  <= fresh_q + LIM_W'(1);
								status_q <= ST_ALLOC;
								done_q   <= 1'b1;
							end else if (!hstat.empty) begin
								cmd_q.pop <= 1'b1;
								state_q   <= T_POP;
							end else begin
								status_q <= ST_EXHAUSTED;
								done_q   <= 1'b1;
							end
						end else if (hstat.full) begin
							status_q <= ST_DROPPED;
							done_q   <= 1'b1;
						end else begin
							// hold the freed id; the request side may move on
							fid_q    <= freed_id;
							mod_go_q <= 1'b1;
							state_q  <= T_MOD;
						end
					end
				end
				T_MOD: begin
					if (mod_done) begin
						cmd_q.push <= 1'b1;
						state_q    <= T_PUSH;
					end
				end
				T_PUSH: begin
					if (hstat.done) begin
						status_q <= ST_FREED;
						done_q   <= 1'b1;
						state_q  <= T_IDLE;
					end
				end
				T_POP: begin
					if (hstat.done) begin
						given_q  <= pop_val[GIVEN_W-1:0];
						status_q <= ST_ALLOC;
						done_q   <= 1'b1;
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy     = (state_q != T_IDLE);
	assign done     = done_q;
	assign given_id = given_q;
	assign status   = status_q;

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("accepted request neither works nor ends");
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_ALLOC |-> given_id == '0) else $error("nonzero id without allocate");
	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start)) else $error("result without a request");
	a_heap_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.pop |-> !hstat.empty) else $error("pop from empty heap");
endmodule
`default_nettype wire
